// ===== sv/rotated_sprite_quad_setup_defines.svh =====
// Assertion macros used by the sprite quad setup top level.
// No dependencies.
`ifndef ROTATED_SPRITE_QUAD_SETUP_DEFINES_SVH
`define ROTATED_SPRITE_QUAD_SETUP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define RSQ_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RSQ_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`endif

// ===== sv/rsq_pkg.sv =====
// Package for the sprite quad setup: beat structs, CORDIC tables and constants.
// No dependencies.
package rsq_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS = 16;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

	typedef struct packed {
		logic [31:0] color;
		logic [15:0] tex_height;
		logic [15:0] tex_width;
		logic [63:0] src_rect;
		logic signed [31:0] depth;
		logic signed [31:0] pivot_y;
		logic signed [31:0] pivot_x;
		logic [15:0] angle;
		logic signed [31:0] dst_h;
		logic signed [31:0] dst_w;
		logic signed [31:0] dst_y;
		logic signed [31:0] dst_x;
	} sprite_t;

	typedef struct packed {
		logic last;
		logic [1:0] corner;
		logic [31:0] vertex_color;
		logic signed [31:0] tex_v;
		logic signed [31:0] tex_u;
		logic signed [31:0] pos_z;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_x;
	} vertex_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic signed [33:0] atan_turn(input logic [3:0] i);
		case (i)
			4'd0: atan_turn = 34'sh020000000;
			4'd1: atan_turn = 34'sh012E4051E;
			4'd2: atan_turn = 34'sh009FB385B;
			4'd3: atan_turn = 34'sh0051111D4;
			4'd4: atan_turn = 34'sh0028B0D43;
			4'd5: atan_turn = 34'sh00145D7E1;
			4'd6: atan_turn = 34'sh000A2F61E;
			4'd7: atan_turn = 34'sh000517C55;
			4'd8: atan_turn = 34'sh00028BE53;
			4'd9: atan_turn = 34'sh000145F2F;
			4'd10: atan_turn = 34'sh0000A2F98;
			4'd11: atan_turn = 34'sh0000517CC;
			4'd12: atan_turn = 34'sh000028BE6;
			4'd13: atan_turn = 34'sh0000145F3;
			4'd14: atan_turn = 34'sh00000A2FA;
			default: atan_turn = 34'sh00000517D;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) sat32 = 32'sh7FFFFFFF;
		else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
		else sat32 = v[31:0];
	endfunction
endpackage

// ===== sv/rsq_cordic.sv =====
// Pipelined CORDIC: cosine and sine in Q28 from a 16-bit turn fraction.
// Depends on rsq_pkg; one register stage per iteration plus in and out stages.
module rsq_cordic (
	input  logic clk,
	input  logic [15:0] angle,
	output logic signed [31:0] cos_q,
	output logic signed [31:0] sin_q
);
	import rsq_pkg::*;
	localparam int N = CORDIC_STEPS;

	logic signed [33:0] x_s [0:N];
	logic signed [33:0] y_s [0:N];
	logic signed [33:0] z_s [0:N];
	logic flip_s [0:N];
	logic [31:0] t;
	logic fl;

	// Fold the angle into a quarter turn either side of zero.
	always_comb begin
		t = {angle, 16'h0};
		fl = (t >= 32'h40000000) && (t < 32'hC0000000);
		if (fl) t = t - 32'h80000000;
	end

	always_ff @(posedge clk) begin
		x_s[0] <= CORDIC_GAIN;
		y_s[0] <= '0;
		z_s[0] <= {{2{t[31]}}, t};
		flip_s[0] <= fl;
	end

	// One micro-rotation per stage.
	for (genvar i = 0; i < N; i++) begin : g_it
		always_ff @(posedge clk) begin
			flip_s[i+1] <= flip_s[i];
			if (!z_s[i][33]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - atan_turn(4'(i));
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + atan_turn(4'(i));
			end
		end
	end

	logic signed [33:0] xf, yf, xr, yr;
	always_comb begin
		xf = flip_s[N] ? -x_s[N] : x_s[N];
		yf = flip_s[N] ? -y_s[N] : y_s[N];
		xr = (xf + 34'sd2) >>> 2;
		yr = (yf + 34'sd2) >>> 2;
	end

	always_ff @(posedge clk) begin
		cos_q <= xr[31:0];
		sin_q <= yr[31:0];
	end
endmodule

// ===== sv/rsq_uvdiv.sv =====
// Pipelined restoring divider for UV: round(n * 2^F / size), ties away.
// Depends on rsq_pkg; one quotient bit per stage.
module rsq_uvdiv #(
	parameter int FRAC_BITS = rsq_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic signed [16:0] num,
	input  logic [15:0] size,
	output logic signed [31:0] quo
);
	import rsq_pkg::*;
	// Numerator 2*|n|*2^F + size fits in QW bits.
	localparam int QW = 17 + FRAC_BITS + 2;
	localparam int DW = 17;

	logic [QW-1:0] n_s [0:QW];
	logic [DW:0] r_s [0:QW];
	logic [DW-1:0] d_s [0:QW];
	logic neg_s [0:QW];
	logic zs_s [0:QW];
	logic nz_s [0:QW];
	logic [16:0] mag;

	always_comb mag = num[16] ? 17'(-num) : 17'(num);

	always_ff @(posedge clk) begin
		n_s[0] <= (QW'(mag) << (FRAC_BITS + 1)) + QW'(size);
		r_s[0] <= '0;
		d_s[0] <= {size, 1'b0};
		neg_s[0] <= num[16];
		zs_s[0] <= (size == 16'd0);
		nz_s[0] <= (num != 17'sd0);
	end

	// One quotient bit per stage, shifted into the numerator word.
	for (genvar i = 0; i < QW; i++) begin : g_st
		logic [DW:0] rt;
		always_comb rt = {r_s[i][DW-1:0], n_s[i][QW-1]};
		always_ff @(posedge clk) begin
			neg_s[i+1] <= neg_s[i];
			zs_s[i+1] <= zs_s[i];
			nz_s[i+1] <= nz_s[i];
			d_s[i+1] <= d_s[i];
			if (rt >= {1'b0, d_s[i]}) begin
				r_s[i+1] <= rt - {1'b0, d_s[i]};
				n_s[i+1] <= {n_s[i][QW-2:0], 1'b1};
			end else begin
				r_s[i+1] <= rt;
				n_s[i+1] <= {n_s[i][QW-2:0], 1'b0};
			end
		end
	end

	logic signed [65:0] qs;
	always_comb begin
		qs = neg_s[QW] ? -66'(n_s[QW]) : 66'(n_s[QW]);
		if (zs_s[QW])
			quo = !nz_s[QW] ? 32'sd0 : (neg_s[QW] ? 32'sh80000000 : 32'sh7FFFFFFF);
		else
			quo = sat32(qs);
	end
endmodule

// ===== sv/rotated_sprite_quad_setup.sv =====
// Top level of the sprite quad setup: sprite queue, trig and UV pipelines, rotation.
// Depends on rsq_pkg, rsq_cordic, rsq_uvdiv and the assertion header.
`include "rotated_sprite_quad_setup_defines.svh"
// Channel | Handshake             | Beat
// sprite  | start / busy          | rsq_pkg::sprite_t, one per sprite
// vertex  | vertex_valid strobe   | rsq_pkg::vertex_t, four per sprite
// A sprite leaves the output port as four consecutive vertex beats; the
// serializer, not the computation pipeline, sets the sustained sprite rate.
// With an empty queue the first vertex follows the accepting edge once the sprite
// has passed the UV dividers (most of the delay), the record queue and rotation.
// busy rises when sprites in flight plus queued reach the queue depth less two.
// Reset clears valid bits, counters and queue pointers only. Results cannot be stalled.
module rotated_sprite_quad_setup #(
	parameter int FRAC_BITS = rsq_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  rsq_pkg::sprite_t sprite,
	output logic vertex_valid,
	output rsq_pkg::vertex_t vertex
);
	import rsq_pkg::*;
	localparam int LAT = 17 + FRAC_BITS + 3;
	localparam int LW = 17 + FRAC_BITS + 2;

	// Computation pipeline: sprite data and valid delayed alongside units.
	logic acc;
	assign acc = start && !busy;

	sprite_t sp_s [0:LAT];
	logic v_s [0:LAT];
	always_ff @(posedge clk) sp_s[0] <= sprite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else v_s[0] <= acc;
	end
	for (genvar i = 0; i < LAT; i++) begin : g_dl
		always_ff @(posedge clk) sp_s[i+1] <= sp_s[i];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i+1] <= 1'b0;
			else v_s[i+1] <= v_s[i];
		end
	end

	// Trig of the angle, delayed to line up with the UV results.
	logic signed [31:0] c_w, s_w;
	rsq_cordic u_cordic (.clk(clk), .angle(sprite.angle),
		.cos_q(c_w), .sin_q(s_w));
	logic signed [31:0] c_d [0:LAT-17];
	logic signed [31:0] s_d [0:LAT-17];
	assign c_d[0] = c_w;
	assign s_d[0] = s_w;
	for (genvar i = 0; i < LAT - 17; i++) begin : g_cd
		always_ff @(posedge clk) begin
			c_d[i+1] <= c_d[i];
			s_d[i+1] <= s_d[i];
		end
	end

	// Four UV dividers on the source edges.
	logic signed [16:0] un0, un1, vn0, vn1;
	always_comb begin
		un0 = 17'(signed'(sprite.src_rect[15:0]));
		vn0 = 17'(signed'(sprite.src_rect[31:16]));
		un1 = un0 + 17'(signed'(sprite.src_rect[47:32]));
		vn1 = vn0 + 17'(signed'(sprite.src_rect[63:48]));
	end
	logic signed [31:0] u0_w, u1_w, v0_w, v1_w;
	rsq_uvdiv #(.FRAC_BITS(FRAC_BITS)) u_du0 (.clk(clk), .num(un0),
		.size(sprite.tex_width), .quo(u0_w));
	rsq_uvdiv #(.FRAC_BITS(FRAC_BITS)) u_du1 (.clk(clk), .num(un1),
		.size(sprite.tex_width), .quo(u1_w));
	rsq_uvdiv #(.FRAC_BITS(FRAC_BITS)) u_dv0 (.clk(clk), .num(vn0),
		.size(sprite.tex_height), .quo(v0_w));
	rsq_uvdiv #(.FRAC_BITS(FRAC_BITS)) u_dv1 (.clk(clk), .num(vn1),
		.size(sprite.tex_height), .quo(v1_w));

	// Sprite aligned with the divider outputs at index LW.
	logic signed [31:0] u0_a, u1_a, v0_a, v1_a;
	sprite_t sa;
	always_comb begin
		sa = sp_s[LW];
		if (sa.tex_width == 16'd0) begin
			u0_a = '0; v0_a = '0;
			u1_a = 32'(1) << FRAC_BITS;
			v1_a = 32'(1) << FRAC_BITS;
		end else begin
			u0_a = u0_w; u1_a = u1_w; v0_a = v0_w; v1_a = v1_w;
		end
	end
	logic signed [31:0] u0_q, u1_q, v0_q, v1_q;
	always_ff @(posedge clk) begin
		u0_q <= u0_a; u1_q <= u1_a; v0_q <= v0_a; v1_q <= v1_a;
	end

	// Sprite plus results at index LW+1 go into a queue of records.
	typedef struct packed {
		sprite_t sp;
		logic signed [31:0] c;
		logic signed [31:0] s;
		logic signed [31:0] u0, u1, v0, v1;
	} rec_t;
	localparam int QD = 64;
	localparam int QA = 6;
	rec_t mem [0:QD-1];
	logic [QA:0] wp_q, rp_q, cnt_w;
	rec_t wr;
	always_comb begin
		wr.sp = sp_s[LW+1];
		wr.c = c_d[LAT-17];
		wr.s = s_d[LAT-17];
		wr.u0 = u0_q; wr.u1 = u1_q; wr.v0 = v0_q; wr.v1 = v1_q;
	end
	always_ff @(posedge clk) if (v_s[LW+1]) mem[wp_q[QA-1:0]] <= wr;

	// Serializer: four vertices per record, one per cycle.
	logic [1:0] k_q;
	logic act_q;
	rec_t rd_q;
	logic pop;
	assign cnt_w = wp_q - rp_q;
	assign pop = (cnt_w != '0) && (!act_q || k_q == 2'd3);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; k_q <= '0; act_q <= 1'b0;
		end else begin
			if (v_s[LW+1]) wp_q <= wp_q + 1'b1;
			if (pop) begin
				rp_q <= rp_q + 1'b1;
				act_q <= 1'b1;
				k_q <= 2'd0;
			end else if (act_q) begin
				if (k_q == 2'd3) act_q <= 1'b0;
				else k_q <= k_q + 2'd1;
			end
		end
	end
	always_ff @(posedge clk) if (pop) rd_q <= mem[rp_q[QA-1:0]];

	// Admission: sprites in flight plus queued stay below the queue depth.
	logic [QA:0] tot_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tot_q <= '0;
		else tot_q <= tot_q + (QA+1)'(acc) - (QA+1)'(pop);
	end
	assign busy = tot_q >= (QA+1)'(QD - 2);

	// Corner, delta and products.
	logic signed [32:0] cx, cy;
	logic signed [33:0] dx, dy;
	always_comb begin
		cx = (k_q == 2'd1 || k_q == 2'd2) ?
			33'(rd_q.sp.dst_x) + 33'(rd_q.sp.dst_w) : 33'(rd_q.sp.dst_x);
		cy = (k_q[1]) ? 33'(rd_q.sp.dst_y) + 33'(rd_q.sp.dst_h) : 33'(rd_q.sp.dst_y);
		dx = 34'(cx) - 34'(rd_q.sp.pivot_x);
		dy = 34'(cy) - 34'(rd_q.sp.pivot_y);
	end
	logic signed [65:0] pxc_s1, pys_s1, pxs_s1, pyc_s1;
	vertex_t b_s1, b_s2, b_s3;
	logic signed [32:0] cx_s1, cy_s1;
	logic rot_s1, rot_s2, ov_s1, ov_s2, ov_s3;
	logic signed [31:0] px_s1, py_s1, px_s2, py_s2;
	always_ff @(posedge clk) begin
		pxc_s1 <= 66'(dx) * 66'(rd_q.c);
		pys_s1 <= 66'(dy) * 66'(rd_q.s);
		pxs_s1 <= 66'(dx) * 66'(rd_q.s);
		pyc_s1 <= 66'(dy) * 66'(rd_q.c);
		cx_s1 <= cx; cy_s1 <= cy;
		rot_s1 <= rd_q.sp.angle != 16'd0;
		px_s1 <= rd_q.sp.pivot_x; py_s1 <= rd_q.sp.pivot_y;
		b_s1.pos_x <= '0; b_s1.pos_y <= '0;
		b_s1.pos_z <= rd_q.sp.depth;
		b_s1.tex_u <= (k_q == 2'd1 || k_q == 2'd2) ? rd_q.u1 : rd_q.u0;
		b_s1.tex_v <= k_q[1] ? rd_q.v1 : rd_q.v0;
		b_s1.vertex_color <= rd_q.sp.color;
		b_s1.corner <= k_q;
		b_s1.last <= k_q == 2'd3;
	end
	logic signed [65:0] rx_s2, ry_s2;
	always_ff @(posedge clk) begin
		rx_s2 <= rot_s1 ? pxc_s1 - pys_s1 : 66'(cx_s1);
		ry_s2 <= rot_s1 ? pxs_s1 + pyc_s1 : 66'(cy_s1);
		rot_s2 <= rot_s1; px_s2 <= px_s1; py_s2 <= py_s1;
		b_s2 <= b_s1;
	end
	logic signed [65:0] fx, fy;
	always_comb begin
		fx = rot_s2 ? ((rx_s2 + 66'sd134217728) >>> 28) + 66'(px_s2) : rx_s2;
		fy = rot_s2 ? ((ry_s2 + 66'sd134217728) >>> 28) + 66'(py_s2) : ry_s2;
	end
	always_ff @(posedge clk) begin
		b_s3.pos_x <= sat32(fx);
		b_s3.pos_y <= sat32(fy);
		b_s3.pos_z <= b_s2.pos_z;
		b_s3.tex_u <= b_s2.tex_u;
		b_s3.tex_v <= b_s2.tex_v;
		b_s3.vertex_color <= b_s2.vertex_color;
		b_s3.corner <= b_s2.corner;
		b_s3.last <= b_s2.last;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_s1 <= 1'b0; ov_s2 <= 1'b0; ov_s3 <= 1'b0;
		end else begin
			ov_s1 <= act_q; ov_s2 <= ov_s1; ov_s3 <= ov_s2;
		end
	end
	assign vertex_valid = ov_s3;
	assign vertex = b_s3;

	`RSQ_ASSERT_IMP(a_q_noovf, clk, arst_n, 1'b1, cnt_w <= (QA+1)'(QD))
	`RSQ_ASSERT_NXT(a_pop_act, clk, arst_n, pop, act_q && k_q == 2'd0)
	`RSQ_ASSERT_IMP(a_last_c3, clk, arst_n, vertex_valid && vertex.last,
		vertex.corner == 2'd3)
	`RSQ_ASSERT_NXT(a_k_step, clk, arst_n, act_q && k_q != 2'd3,
		act_q && k_q == $past(k_q) + 2'd1)
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the rotated sprite quad setup block.
// Depends on rsq_pkg and rotated_sprite_quad_setup; predicts four vertices per sprite.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import rsq_pkg::*;

	localparam int FB = 16;
	localparam int CORNER_TL = 0;
	localparam int CORNER_TR = 1;
	localparam int CORNER_BR = 2;
	localparam int CORNER_BL = 3;
	localparam int NUM_RANDOM = 345;
	localparam int SETTLE_CYCLES = 80;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	sprite_t sprite;
	logic vertex_valid;
	vertex_t vertex;

	sprite_t sprite_q[$];
	vertex_t vertex_exp_q[$];
	int errors;
	bit drain_req;
	bit drain_done;

	rotated_sprite_quad_setup u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sprite(sprite), .vertex_valid(vertex_valid), .vertex(vertex)
	);

	// Clock: 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Fixed-point helpers at the block's widths.
	function automatic longint asr64(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'h7FFFFFFF;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic longint atan_step(int i);
		longint tbl[16] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
			64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
			64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
			64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
		return tbl[i];
	endfunction

	// CORDIC sine and cosine in Q28 for an angle in 1/65536 turn.
	task automatic sin_cos_q28(input logic [15:0] ang, output longint c, output longint s);
		logic [31:0] t;
		bit flip;
		longint x, y, z, xs, ys;
		t = {ang, 16'h0000};
		flip = 1'b0;
		x = 64'h26DD3B6A;
		y = 0;
		if (t >= 32'h40000000 && t < 32'hC0000000) begin
			t = t - 32'h80000000;
			flip = 1'b1;
		end
		z = longint'(signed'(t));
		for (int i = 0; i < 16; i++) begin
			xs = asr64(x, i);
			ys = asr64(y, i);
			if (z >= 0) begin
				x -= ys; y += xs; z -= atan_step(i);
			end else begin
				x += ys; y -= xs; z += atan_step(i);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = asr64(x + 2, 2);
		s = asr64(y + 2, 2);
	endtask

	// Texel over texture size, rounded half away from zero.
	function automatic logic [31:0] texel_to_uv(longint n, logic [15:0] size);
		longint mag, q;
		longint unsigned num;
		if (size == 0) return n > 0 ? 32'h7FFFFFFF : (n < 0 ? 32'h80000000 : 32'h0);
		mag = n < 0 ? -n : n;
		num = (longint'(mag) << FB) * 2 + size;
		q = longint'(num / (2 * longint'(size)));
		return clamp32(n < 0 ? -q : q);
	endfunction

	// Expected vertices of one sprite, appended to the queue.
	task automatic predict_quad(input sprite_t sp);
		longint cx[4], cy[4], us[2], vs[2];
		longint c, s, dx, dy, rx, ry, px, py;
		logic [31:0] ox, oy;
		vertex_t v;
		longint sxv, syv, swv, shv;
		cx[0] = sp.dst_x; cy[0] = sp.dst_y;
		cx[1] = longint'(sp.dst_x) + sp.dst_w; cy[1] = sp.dst_y;
		cx[2] = cx[1]; cy[2] = longint'(sp.dst_y) + sp.dst_h;
		cx[3] = sp.dst_x; cy[3] = cy[2];
		px = sp.pivot_x;
		py = sp.pivot_y;
		c = 0;
		s = 0;
		if (sp.angle != 0) sin_cos_q28(sp.angle, c, s);
		sxv = signed'(sp.src_rect[15:0]);
		syv = signed'(sp.src_rect[31:16]);
		swv = signed'(sp.src_rect[47:32]);
		shv = signed'(sp.src_rect[63:48]);
		if (sp.tex_width != 0) begin
			us[0] = signed'(texel_to_uv(sxv, sp.tex_width));
			us[1] = signed'(texel_to_uv(sxv + swv, sp.tex_width));
			vs[0] = signed'(texel_to_uv(syv, sp.tex_height));
			vs[1] = signed'(texel_to_uv(syv + shv, sp.tex_height));
		end else begin
			us[0] = 0; vs[0] = 0;
			us[1] = 1 << FB; vs[1] = 1 << FB;
		end
		for (int k = CORNER_TL; k <= CORNER_BL; k++) begin
			if (sp.angle != 0) begin
				dx = cx[k] - px;
				dy = cy[k] - py;
				rx = dx * c - dy * s;
				ry = dx * s + dy * c;
				ox = clamp32(asr64(rx + (64'sd1 <<< 27), 28) + px);
				oy = clamp32(asr64(ry + (64'sd1 <<< 27), 28) + py);
			end else begin
				ox = clamp32(cx[k]);
				oy = clamp32(cy[k]);
			end
			v.pos_x = ox;
			v.pos_y = oy;
			v.pos_z = sp.depth;
			v.tex_u = us[(k == CORNER_TR || k == CORNER_BR) ? 1 : 0][31:0];
			v.tex_v = vs[(k >= CORNER_BR) ? 1 : 0][31:0];
			v.vertex_color = sp.color;
			v.corner = k[1:0];
			v.last = (k == CORNER_BL);
			vertex_exp_q.insert(vertex_exp_q.size(), v);
		end
	endtask

	function automatic logic [31:0] rand_fix();
		case ($urandom_range(0, 5))
			0: return 32'h80000000 | $urandom_range(0, 3);
			1: return 32'h7FFFFFFF - $urandom_range(0, 3);
			2: return $urandom;
			default: return {{8{1'b0}}, 24'($urandom)} - 32'h00800000;
		endcase
	endfunction

	function automatic sprite_t rand_sprite();
		sprite_t sp;
		sp.dst_x = rand_fix();
		sp.dst_y = rand_fix();
		sp.dst_w = rand_fix();
		sp.dst_h = rand_fix();
		sp.pivot_x = rand_fix();
		sp.pivot_y = rand_fix();
		sp.depth = $urandom;
		sp.angle = ($urandom_range(0, 4) == 0) ? 16'h0 : 16'($urandom);
		sp.src_rect = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: sp.tex_width = 16'h0;
			1: sp.tex_width = 16'hFFFF;
			default: sp.tex_width = 16'($urandom_range(1, 4096));
		endcase
		case ($urandom_range(0, 7))
			0: sp.tex_height = 16'h0;
			1: sp.tex_height = 16'hFFFF;
			default: sp.tex_height = 16'($urandom_range(1, 4096));
		endcase
		sp.color = $urandom;
		return sp;
	endfunction

	// Stimulus: directed sprites first, then random ones.
	initial begin
		sprite_t sp;
		logic [15:0] angs[10] = '{16'h0001, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
			16'h3FFF, 16'h4001, 16'hBFFF, 16'h2000, 16'h1234};
		sp = '0;
		sprite_q.insert(sprite_q.size(), sp);
		sp = '1;
		sprite_q.insert(sprite_q.size(), sp);
		// Corner sums overflow both ways without rotation.
		sp = '0;
		sp.dst_x = 32'h7FFFFFFF; sp.dst_w = 32'h7FFFFFFF;
		sp.dst_y = 32'h80000000; sp.dst_h = 32'h80000000;
		sp.tex_width = 16'd64; sp.tex_height = 16'd0;
		sp.src_rect = {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000};
		sprite_q.insert(sprite_q.size(), sp);
		// Texture present with zero height and a zero numerator.
		sp = '0;
		sp.tex_width = 16'd3; sp.tex_height = 16'd0;
		sp.src_rect = {16'h0000, 16'h0001, 16'h0001, 16'hFFFF};
		sp.color = 32'hA5A55A5A;
		sprite_q.insert(sprite_q.size(), sp);
		// UV divides by the largest and the smallest texture size.
		sp = '0;
		sp.tex_width = 16'hFFFF; sp.tex_height = 16'd1;
		sp.src_rect = {16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001};
		sprite_q.insert(sprite_q.size(), sp);
		// Rotation across the quadrant fold and with extreme pivots.
		foreach (angs[i]) begin
			sp = rand_sprite();
			sp.angle = angs[i];
			if (i == 3) begin
				sp.pivot_x = 32'h80000000; sp.pivot_y = 32'h7FFFFFFF;
			end
			sprite_q.insert(sprite_q.size(), sp);
		end
		for (int i = 0; i < NUM_RANDOM; i++) sprite_q.insert(sprite_q.size(), rand_sprite());
	end

	// Driver: issues sprites at the falling edge with random gaps.
	int gap_left;
	int sent;
	bit taken;
	always @(negedge clk) begin
		if (arst_n !== 1'b1) begin
			start <= 1'b0;
			gap_left <= 0;
		end else if (start && !taken) begin
			start <= 1'b1;
		end else if (drain_req && vertex_exp_q.size() != 0) begin
			start <= 1'b0;
		end else if (gap_left > 0) begin
			start <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (sprite_q.size() != 0) begin
			sprite <= sprite_q[0];
			sprite_q.pop_front();
			start <= 1'b1;
			sent <= sent + 1;
			gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
				: (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
		end else begin
			start <= 1'b0;
		end
	end

	// Acceptance is tracked at the rising edge, where the prediction is made.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			predict_quad(sprite);
			taken <= 1'b1;
		end else begin
			taken <= 1'b0;
		end
	end

	// Hold off once mid-run until the block has drained.
	always @(negedge clk) begin
		if (sent == 200 && !drain_done) begin
			drain_req <= 1'b1;
			drain_done <= 1'b1;
		end else if (drain_req && vertex_exp_q.size() == 0 && !start) drain_req <= 1'b0;
	end

	// Monitor: compare every vertex beat with the oldest expectation.
	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && vertex_valid) begin
			if (vertex_exp_q.size() == 0) begin
				$error("unexpected vertex beat");
				errors++;
			end else begin
				e = vertex_exp_q.pop_front();
				if (vertex.pos_x !== e.pos_x) begin
					$error("pos_x exp %h got %h", e.pos_x, vertex.pos_x); errors++;
				end
				if (vertex.pos_y !== e.pos_y) begin
					$error("pos_y exp %h got %h", e.pos_y, vertex.pos_y); errors++;
				end
				if (vertex.pos_z !== e.pos_z) begin
					$error("pos_z exp %h got %h", e.pos_z, vertex.pos_z); errors++;
				end
				if (vertex.tex_u !== e.tex_u) begin
					$error("tex_u exp %h got %h", e.tex_u, vertex.tex_u); errors++;
				end
				if (vertex.tex_v !== e.tex_v) begin
					$error("tex_v exp %h got %h", e.tex_v, vertex.tex_v); errors++;
				end
				if (vertex.vertex_color !== e.vertex_color) begin
					$error("vertex_color exp %h got %h", e.vertex_color,
						vertex.vertex_color);
					errors++;
				end
				if (vertex.corner !== e.corner) begin
					$error("corner exp %0d got %0d", e.corner, vertex.corner); errors++;
				end
				if (vertex.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, vertex.last); errors++;
				end
			end
		end
	end

	// Reset, then wait for all sprites to be taken and all vertices to arrive.
	initial begin
		errors = 0;
		sent = 0;
		drain_req = 1'b0;
		drain_done = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		sprite = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (sprite_q.size() == 0);
		@(posedge clk);
		while (start || vertex_exp_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && vertex_exp_q.size() == 0) $display("** rotated_sprite_quad_setup: PASSED **");
		else $display("** rotated_sprite_quad_setup: FAILED **");
		$finish;
	end

	// Watchdog.
	initial begin
		#2ms;
		$display("** rotated_sprite_quad_setup: FAILED **");
		$finish;
	end
endmodule

// ===== rotated_sprite_quad_setup.f =====
+incdir+sv
sv/rsq_pkg.sv
sv/rsq_cordic.sv
sv/rsq_uvdiv.sv
sv/rotated_sprite_quad_setup.sv
tb/sv/tb_top.sv
